FILE: rtl/core/gelu_pkg.sv
// Shared types, fixed-point constants and helpers for the GELU (erf form) pipeline.
// Depends on nothing; every module of the block imports it.
package gelu_pkg;

    // Internal fixed point: 30 fraction bits.
    localparam int QB = 30;
    localparam logic [63:0] ONE64  = 64'd1 << QB;
    localparam logic [63:0] HALF64 = 64'd1 << (QB - 1);

    // Constants rounded to nearest at 30 fraction bits.
    localparam logic [63:0] K_A1   = (64'd254829592  * ONE64 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] K_A2   = (64'd284496736  * ONE64 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] K_A3   = (64'd1421413741 * ONE64 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] K_A4   = (64'd1453152027 * ONE64 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] K_A5   = (64'd1061405429 * ONE64 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] K_P    = (64'd3275911 * ONE64 + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] K_ISQ2 = (64'd7071067812 * ONE64 + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] K_LN2  = (64'd693147181 * ONE64 + 64'd500000000) / 64'd1000000000;

    // Reciprocal divider: 31 quotient bits, four per stage.
    localparam int DIV_BITS = 31;
    localparam int DIV_STEP = 4;
    localparam int DIV_STG  = (DIV_BITS + DIV_STEP - 1) / DIV_STEP;

    // Exponential: 14 Taylor terms, result flushed to zero from 2^-40 on.
    localparam int EXP_TERMS  = 14;
    localparam int EXP_N_BITS = 6;
    localparam int EXP_ZERO_N = 40;

    typedef logic signed [33:0] t_acc;

    localparam t_acc C_A1 = t_acc'(K_A1);
    localparam t_acc C_A2 = -t_acc'(K_A2);
    localparam t_acc C_A3 = t_acc'(K_A3);
    localparam t_acc C_A4 = -t_acc'(K_A4);
    localparam t_acc C_A5 = t_acc'(K_A5);

    // One sample in flight, with every intermediate it collects on the way.
    typedef struct packed {
        logic                last;
        logic                neg;
        logic [31:0]         a;      // |x| in input format
        logic [61:0]         pz;     // clamped |x| times 1/sqrt2, unscaled
        logic [33:0]         z;
        logic [31:0]         dv;     // 1 + p*z
        logic [31:0]         rem;    // divider remainder
        logic [30:0]         nlo;    // dividend bits still to shift in
        logic [30:0]         t;      // 1/(1 + p*z)
        t_acc                acc;    // polynomial
        logic [35:0]         u;      // z*z, then its remainder modulo ln2
        logic [5:0]          n;      // power-of-two count of exp(-u)
        logic [31:0]         x;      // Taylor term before division by k
        logic [30:0]         term;
        logic signed [32:0]  sum;
        logic [30:0]         ex;     // exp(-z*z)
        logic [31:0]         fac;    // 1 +/- erf
        logic [33:0]         mag;
    } t_item;

    // Signed times non-negative, rounded half away from zero.
    function automatic t_acc mul_sq(input t_acc a, input logic [30:0] b);
        logic [33:0] m;
        logic [64:0] p;
        logic [33:0] r;
        m = a[33] ? $unsigned(-a) : $unsigned(a);
        p = 65'(m) * 65'(b);
        r = 34'((p + 65'(HALF64)) >> QB);
        return a[33] ? -t_acc'(r) : t_acc'(r);
    endfunction

endpackage

FILE: rtl/core/gelu_div.sv
// Pipelined restoring divider that forms t = round(2^60 / d), four quotient bits a stage.
// Depends on gelu_pkg for the item type and divider sizes.
module gelu_div import gelu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_item r_stg [DIV_STG];
    logic  r_vld [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        t_item n_stg;
        t_item w_in;
        logic  w_vin;

        if (s == 0) begin : g_first
            always_comb begin
                w_in     = i_item;
                w_in.rem = 32'd1 << (QB - 1);
                w_in.nlo = i_item.dv[31:1];
                w_in.t   = '0;
            end
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_stg[s-1];
            assign w_vin = r_vld[s-1];
        end

        always_comb begin
            logic [32:0] w_r;
            w_r   = '0;
            n_stg = w_in;
            for (int j = 0; j < DIV_STEP; j++) begin
                if (s * DIV_STEP + j < DIV_BITS) begin
                    w_r       = {n_stg.rem, n_stg.nlo[30]};
                    n_stg.nlo = n_stg.nlo << 1;
                    if (w_r >= 33'(n_stg.dv)) begin
                        n_stg.rem = 32'(w_r - 33'(n_stg.dv));
                        n_stg.t   = {n_stg.t[29:0], 1'b1};
                    end else begin
                        n_stg.rem = w_r[31:0];
                        n_stg.t   = {n_stg.t[29:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[s] <= n_stg;
            end
        end
    end

    assign o_valid = r_vld[DIV_STG-1];
    assign o_item  = r_stg[DIV_STG-1];

endmodule

FILE: rtl/core/gelu_poly.sv
// Horner evaluation of the fifth-order erf polynomial in t, one multiply per stage.
// Depends on gelu_pkg for coefficients, the item type and mul_sq.
module gelu_poly import gelu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam int POLY_STG = 5;
    localparam t_acc ADD_C [POLY_STG] = '{C_A4, C_A3, C_A2, C_A1, t_acc'(0)};

    t_item r_stg [POLY_STG];
    logic  r_vld [POLY_STG];

    for (genvar s = 0; s < POLY_STG; s++) begin : g_stg
        t_item n_stg;
        t_item w_in;
        logic  w_vin;

        if (s == 0) begin : g_first
            always_comb begin
                w_in     = i_item;
                w_in.acc = C_A5;
            end
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_stg[s-1];
            assign w_vin = r_vld[s-1];
        end

        always_comb begin
            n_stg     = w_in;
            n_stg.acc = mul_sq(w_in.acc, w_in.t) + ADD_C[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[s] <= n_stg;
            end
        end
    end

    assign o_valid = r_vld[POLY_STG-1];
    assign o_item  = r_stg[POLY_STG-1];

endmodule

FILE: rtl/core/gelu_exp.sv
// Pipelined exp(-z*z): square, split by ln2, 14-term Taylor series, final power-of-two shift.
// Depends on gelu_pkg for the item type and constants.
module gelu_exp import gelu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    // Square, two split stages, three stages per Taylor term, final shift.
    localparam int SPLIT_STG = 2;
    localparam int SPLIT_PER = EXP_N_BITS / SPLIT_STG;
    localparam int TAY_FIRST = 1 + SPLIT_STG;
    localparam int EXP_STG   = TAY_FIRST + 3 * EXP_TERMS + 1;

    t_item r_stg [EXP_STG];
    logic  r_vld [EXP_STG];

    for (genvar s = 0; s < EXP_STG; s++) begin : g_stg
        t_item n_stg;
        t_item w_in;
        logic  w_vin;

        if (s == 0) begin : g_first
            assign w_in  = i_item;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_stg[s-1];
            assign w_vin = r_vld[s-1];
        end

        if (s == 0) begin : g_square
            logic [3:0]  w_zh;
            logic [29:0] w_zl;
            assign w_zh = w_in.z[33:30];
            assign w_zl = w_in.z[29:0];
            always_comb begin
                n_stg   = w_in;
                n_stg.u = 36'((64'(w_zh) * 64'(w_zh)) << QB)
                        + 36'((64'(w_zh) * 64'(w_zl)) << 1)
                        + 36'((64'(w_zl) * 64'(w_zl) + HALF64) >> QB);
            end
        end else if (s < TAY_FIRST) begin : g_split
            always_comb begin
                int          bb;
                logic [35:0] w_lim;
                n_stg = w_in;
                if (s == 1) begin
                    n_stg.n = '0;
                end
                for (int j = 0; j < SPLIT_PER; j++) begin
                    bb    = EXP_N_BITS - 1 - ((s - 1) * SPLIT_PER + j);
                    w_lim = 36'(K_LN2 << bb);
                    if (n_stg.u >= w_lim) begin
                        n_stg.u           = n_stg.u - w_lim;
                        n_stg.n[3'(bb)]   = 1'b1;
                    end
                end
            end
        end else if (s < EXP_STG - 1) begin : g_taylor
            localparam int unsigned KD = (s - TAY_FIRST) / 3 + 1;
            localparam int          PH = (s - TAY_FIRST) % 3;
            localparam logic [32:0] RECIP = 33'((64'd1 << 32) / KD);

            if (PH == 0) begin : g_mul
                always_comb begin
                    logic [30:0] w_term;
                    logic [61:0] w_p;
                    n_stg  = w_in;
                    w_term = w_in.term;
                    if (KD == 1) begin
                        w_term    = 31'(ONE64);
                        n_stg.sum = 33'(ONE64);
                    end
                    w_p     = 62'(w_term) * 62'(w_in.u[29:0]);
                    n_stg.x = 32'(((w_p + 62'(HALF64)) >> QB) + 62'(KD / 2));
                end
            end else if (PH == 1) begin : g_recip
                always_comb begin
                    logic [64:0] w_p;
                    n_stg      = w_in;
                    w_p        = 65'(w_in.x) * 65'(RECIP);
                    n_stg.term = 31'(w_p >> 32);
                end
            end else begin : g_fix
                always_comb begin
                    logic [34:0] w_qk;
                    logic [34:0] w_rm;
                    n_stg = w_in;
                    w_qk  = 35'(w_in.term) * 35'(KD);
                    w_rm  = 35'(w_in.x) - w_qk;
                    if (w_rm >= 35'(KD)) begin
                        n_stg.term = w_in.term + 31'd1;
                    end
                    if (KD % 2 == 1) begin
                        n_stg.sum = w_in.sum - $signed({2'b00, n_stg.term});
                    end else begin
                        n_stg.sum = w_in.sum + $signed({2'b00, n_stg.term});
                    end
                end
            end
        end else begin : g_shift
            always_comb begin
                logic [31:0] w_sp;
                logic [32:0] w_tmp;
                n_stg = w_in;
                w_sp  = w_in.sum[32] ? 32'd0 : w_in.sum[31:0];
                w_tmp = {w_sp, 1'b0} >> w_in.n;
                if (w_in.n >= 6'(EXP_ZERO_N)) begin
                    n_stg.ex = '0;
                end else if (w_in.n == '0) begin
                    n_stg.ex = w_sp[30:0];
                end else begin
                    n_stg.ex = 31'((w_tmp + 33'd1) >> 1);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[s] <= n_stg;
            end
        end
    end

    assign o_valid = r_vld[EXP_STG-1];
    assign o_item  = r_stg[EXP_STG-1];

endmodule

FILE: rtl/core/gelu_erf_activation.sv
// Top level of the GELU activation, erf form, in signed fixed point.
// Depends on gelu_pkg and instantiates gelu_div, gelu_poly and gelu_exp.
//
// Usage: one signed fixed-point sample enters per beat on the input channel
// (i_valid, i_sample_in, i_last_in, stall back on o_stall) and its GELU leaves
// on the output channel (o_valid, o_gelu_out, o_last_out, stall in on i_stall).
// The last flag rides along with its sample unchanged.
// The datapath is one linear pipeline of 66 register stages. A new beat can be
// accepted in every cycle in which o_stall is low: throughput is one sample per
// clock while the receiver does not stall.
// The depth is set by the reciprocal divider (eight stages), the five Horner
// multiplies and the exponential, whose 14 Taylor terms take three stages each.
// When the receiver stalls while a result is waiting in the output register,
// the whole pipeline holds in place and o_stall goes high in the same cycle;
// nothing is dropped or repeated, and bubbles stay where they are.
// The synchronous active-low reset clears every valid bit; payload registers
// are not reset. The block keeps no state between samples.
module gelu_erf_activation import gelu_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_sample_in,
    input  logic                  i_last_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_gelu_out,
    output logic                  o_last_out
);

    // The erf path sees |x| clamped to 8.0; moving to 30 fraction bits is a left shift.
    localparam logic [32:0] CLAMP_LIM = 33'(8) << FRAC_BITS;
    localparam int          ZSH       = QB - FRAC_BITS;
    localparam logic [33:0] POS_MAX   = (34'd1 << (DATA_WIDTH - 1)) - 34'd1;
    localparam logic [33:0] NEG_MAX   = 34'd1 << (DATA_WIDTH - 1);

    // One enable for the whole pipe: it moves unless a result waits and is stalled.
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Front end: magnitude and clamp, z = |x|/sqrt2, then d = 1 + p*z.
    t_item r_f0, r_f1, r_f2, n_f0, n_f1, n_f2;
    logic  r_v0, r_v1, r_v2;

    logic                  w_neg;
    logic [DATA_WIDTH-1:0] w_abs;
    logic [32:0]           w_ac;

    // Negating the most negative code wraps to 2^(DATA_WIDTH-1), which is the right magnitude.
    assign w_neg = i_sample_in[DATA_WIDTH-1];
    assign w_abs = w_neg ? DATA_WIDTH'(~i_sample_in + 1'b1) : i_sample_in;
    assign w_ac  = (33'(w_abs) > CLAMP_LIM) ? CLAMP_LIM : 33'(w_abs);

    always_comb begin
        n_f0      = '0;
        n_f0.last = i_last_in;
        n_f0.neg  = w_neg;
        n_f0.a    = 32'(w_abs);
        n_f0.pz   = 62'(w_ac[31:0]) * 62'(K_ISQ2[29:0]);
    end

    always_comb begin
        logic [63:0] w_zs;
        n_f1   = r_f0;
        w_zs   = 64'(r_f0.pz) << ZSH;
        n_f1.z = 34'((65'(w_zs) + 65'(HALF64)) >> QB);
    end

    always_comb begin
        logic [62:0] w_pp;
        n_f2    = r_f1;
        w_pp    = 63'(r_f1.z) * 63'(K_P);
        n_f2.dv = 32'(ONE64 + ((64'(w_pp) + HALF64) >> QB));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f0 <= n_f0;
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

    // t = 1/(1 + p*z), the erf polynomial in t, and exp(-z*z), one after the other.
    t_item w_div, w_poly, w_exp;
    logic  w_vdiv, w_vpoly, w_vexp;

    gelu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_item  (r_f2),
        .o_valid (w_vdiv),
        .o_item  (w_div)
    );

    gelu_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vdiv),
        .i_item  (w_div),
        .o_valid (w_vpoly),
        .o_item  (w_poly)
    );

    gelu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vpoly),
        .i_item  (w_poly),
        .o_valid (w_vexp),
        .o_item  (w_exp)
    );

    // Back end: erf magnitude, the factor 1 +/- erf, the final product and saturation.
    t_item r_b0, r_b1, r_b2, n_b0, n_b1, n_b2;
    logic  r_vb0, r_vb1, r_vb2;
    logic [DATA_WIDTH-1:0] r_gelu, n_gelu;
    logic                  r_last, r_ovld;

    always_comb begin
        n_b0     = w_exp;
        n_b0.acc = mul_sq(w_exp.acc, w_exp.ex);
    end

    // erf magnitude is 1 - poly*exp, held to [0, 1].
    always_comb begin
        logic signed [35:0] w_e;
        logic [30:0]        w_ec;
        n_b1 = r_b0;
        w_e  = $signed(36'(ONE64)) - 36'(r_b0.acc);
        if (w_e < 0) begin
            w_ec = '0;
        end else if (w_e > $signed(36'(ONE64))) begin
            w_ec = 31'(ONE64);
        end else begin
            w_ec = w_e[30:0];
        end
        n_b1.fac = r_b0.neg ? 32'(ONE64) - 32'(w_ec) : 32'(ONE64) + 32'(w_ec);
    end

    // |x| * factor / 2, rounded.
    always_comb begin
        logic [63:0] w_p;
        n_b2     = r_b1;
        w_p      = 64'(r_b1.a) * 64'(r_b1.fac);
        n_b2.mag = 34'((w_p + ONE64) >> (QB + 1));
    end

    always_comb begin
        if (r_b2.neg) begin
            n_gelu = DATA_WIDTH'(34'd0 - ((r_b2.mag > NEG_MAX) ? NEG_MAX : r_b2.mag));
        end else begin
            n_gelu = DATA_WIDTH'((r_b2.mag > POS_MAX) ? POS_MAX : r_b2.mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb0  <= 1'b0;
            r_vb1  <= 1'b0;
            r_vb2  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vb0  <= w_vexp;
            r_vb1  <= r_vb0;
            r_vb2  <= r_vb1;
            r_ovld <= r_vb2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b0   <= n_b0;
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_gelu <= n_gelu;
            r_last <= r_b2.last;
        end
    end

    assign o_valid    = r_ovld;
    assign o_gelu_out = r_gelu;
    assign o_last_out = r_last;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the GELU (erf form) activation pipeline.
// Needs the block under test with its submodules and gelu_pkg; the bench predicts each beat itself.
module testbench;

    localparam int DW = 16;
    localparam int FB = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    // Fixed-point constants at 30 fraction bits, rounded to nearest.
    localparam logic [63:0] Q_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q_HALF = 64'd1 << 29;
    localparam logic [63:0] C_A1 = (64'd254829592  * Q_ONE + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C_A2 = (64'd284496736  * Q_ONE + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C_A3 = (64'd1421413741 * Q_ONE + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C_A4 = (64'd1453152027 * Q_ONE + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C_A5 = (64'd1061405429 * Q_ONE + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C_P  = (64'd3275911 * Q_ONE + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] C_IS2 =
        (64'd7071067812 * Q_ONE + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C_LN2 = (64'd693147181 * Q_ONE + 64'd500000000) / 64'd1000000000;

    typedef struct {
        logic [DW-1:0] sample;
        logic          last;
    } t_sample_beat;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [DW-1:0] i_sample_in;
    logic          i_last_in;
    logic          o_valid;
    logic          i_stall;
    logic [DW-1:0] o_gelu_out;
    logic          o_last_out;

    gelu_erf_activation #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_gelu_out  (o_gelu_out),
        .o_last_out  (o_last_out)
    );

    t_sample_beat pending_samples[$];   // stimulus not yet offered to the block
    t_sample_beat expected_gelu[$];     // predicted results, oldest first
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           stimulus_done = 0;
    bit           calm_mode = 0;        // when set, neither side inserts gaps

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Signed value times a non-negative one, both with 30 fraction bits,
    // rounded to nearest with ties away from zero.
    function automatic longint q30_mul(input longint a, input logic [63:0] b);
        logic [63:0] m;
        logic [63:0] r;
        m = (a < 0) ? 64'(-a) : 64'(a);
        r = (m * b + Q_HALF) >> 30;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    // exp(-u): range reduction by ln2, then a 14-term Taylor sum.
    function automatic logic [63:0] q30_exp_neg(input logic [63:0] u);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] term;
        longint      sum;
        n = u / C_LN2;
        r = u - n * C_LN2;
        term = Q_ONE;
        sum = longint'(Q_ONE);
        for (int k = 1; k <= 14; k++) begin
            term = (term * r + Q_HALF) >> 30;
            term = (term + 64'(k / 2)) / 64'(k);
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (n >= 64'd40) return 64'd0;
        if (n == 64'd0) return 64'(sum);
        return (64'(sum) + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic logic [DW-1:0] gelu_predict(input logic [DW-1:0] raw);
        logic        neg;
        logic [63:0] a, ac, a30, z, d, t, zh, zl, zz, ex, fac, mag;
        longint      acc, e;
        neg = raw[DW-1];
        a = neg ? 64'(-raw) : 64'(raw);
        if (neg && a == 64'd0) a = 64'd1 << (DW - 1);
        a = a & ((64'd1 << DW) - 1);
        if (neg && a == 64'd0) a = 64'd1 << (DW - 1);
        // The erf path saturates at |x| = 8.
        ac = (a > (64'd8 << FB)) ? (64'd8 << FB) : a;
        a30 = ac << (30 - FB);
        z = (a30 * C_IS2 + Q_HALF) >> 30;
        d = Q_ONE + ((C_P * z + Q_HALF) >> 30);
        t = (Q_ONE * Q_ONE + d / 2) / d;
        // Horner form of the fifth-order polynomial in t.
        acc = longint'(C_A5);
        acc = q30_mul(acc, t) - longint'(C_A4);
        acc = q30_mul(acc, t) + longint'(C_A3);
        acc = q30_mul(acc, t) - longint'(C_A2);
        acc = q30_mul(acc, t) + longint'(C_A1);
        acc = q30_mul(acc, t);
        zh = z >> 30;
        zl = z & (Q_ONE - 1);
        zz = ((zh * zh) << 30) + 2 * zh * zl + ((zl * zl + Q_HALF) >> 30);
        ex = q30_exp_neg(zz);
        e = longint'(Q_ONE) - q30_mul(acc, ex);
        if (e < 0) e = 0;
        if (e > longint'(Q_ONE)) e = longint'(Q_ONE);
        fac = neg ? Q_ONE - 64'(e) : Q_ONE + 64'(e);
        mag = (a * fac + Q_ONE) >> 31;
        if (neg) begin
            if (mag > (64'd1 << (DW - 1))) mag = 64'd1 << (DW - 1);
            return DW'(-mag);
        end
        if (mag > (64'd1 << (DW - 1)) - 1) mag = (64'd1 << (DW - 1)) - 1;
        return DW'(mag);
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_length();
        int pick;
        if (calm_mode) return 0;
        pick = $urandom_range(99);
        if (pick < 65) return 0;
        if (pick < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic add_sample(input logic [DW-1:0] s, input logic l);
        t_sample_beat b;
        b.sample = s;
        b.last = l;
        pending_samples.push_back(b);
    endtask

    // Driver: offers one beat at a time, holding it while the block stalls.
    // Every 200 beats it decides again whether the next stretch runs calm.
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_sample_beat b;
        logic         take_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take_next = !i_valid || !o_stall;
            if (i_valid && !o_stall) begin
                b.sample = gelu_predict(i_sample_in);
                b.last = i_last_in;
                expected_gelu.push_back(b);
            end
            if (take_next) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    b = pending_samples.pop_front();
                    if (pending_samples.size() % 200 == 0)
                        calm_mode = ($urandom_range(3) == 0);
                    i_sample_in <= b.sample;
                    i_last_in <= b.last;
                    i_valid <= 1'b1;
                    send_gap <= gap_length();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall on the result side and comparison of every beat.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_sample_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_gelu.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: gelu %h last %b",
                                 o_gelu_out, o_last_out);
                end else begin
                    want = expected_gelu.pop_front();
                    if (o_gelu_out !== want.sample || o_last_out !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: gelu expected %h got %h, last expected %b got %b",
                                     want.sample, o_gelu_out, want.last, o_last_out);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                recv_gap <= gap_length();
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [DW-1:0] s;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_sample_in = '0;
        i_last_in = 1'b0;

        // Directed beats: zero, smallest steps, the format's extremes, and
        // points around the erf knee on both sides of zero.
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd1, 1'b1);
        add_sample(-16'sd1, 1'b0);
        add_sample(16'sd32767, 1'b1);
        add_sample(16'h8000, 1'b0);
        add_sample(-16'sd32767, 1'b1);
        add_sample(16'sd2048, 1'b0);
        add_sample(-16'sd2048, 1'b0);
        add_sample(16'sd4096, 1'b1);
        add_sample(-16'sd4096, 1'b0);
        add_sample(16'sd8192, 1'b0);
        add_sample(-16'sd8192, 1'b1);
        add_sample(16'sd12288, 1'b0);
        add_sample(-16'sd12288, 1'b0);
        add_sample(16'sd16384, 1'b1);
        add_sample(-16'sd16384, 1'b0);
        add_sample(-16'sd24576, 1'b0);
        add_sample(16'sd24576, 1'b1);
        add_sample(16'h5555, 1'b0);
        add_sample(16'haaaa, 1'b1);

        // Random beats: mostly the whole range, some concentrated near zero
        // where the curve bends.
        for (int i = 0; i < 1700; i++) begin
            if ($urandom_range(3) == 0) s = DW'($urandom_range(16384)) - DW'(8192);
            else                        s = DW'($urandom());
            add_sample(s, 1'(($urandom_range(7) == 0)));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_samples.size() == 0 && !i_valid);
        wait (expected_gelu.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_gelu.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: gelu_erf_activation.f
rtl/core/gelu_pkg.sv
rtl/core/gelu_div.sv
rtl/core/gelu_poly.sv
rtl/core/gelu_exp.sv
rtl/core/gelu_erf_activation.sv
tb/testbench.sv
